FILE: hw/rtl/tdn_pkg.sv
// Shared types, constants and helper functions of the torus distance and normal block.
package tdn_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int AW = 18;
  localparam int RW = 31;
  localparam int NW = 18;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_Q = 18;
  localparam int DIV_DW = 49;

  localparam int FRONT_STAGES = 7;
  localparam int RADIAL_STAGES = 3;
  localparam int CORE_STAGES = 1;
  localparam int SCALE_STAGES = 2;
  localparam int OUT_STAGES = 1;
  localparam int LATENCY = FRONT_STAGES + SQRT_STEPS + RADIAL_STAGES + SQRT_STEPS
                           + CORE_STAGES + DIV_Q + SCALE_STAGES + DIV_Q + OUT_STAGES;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_RING_RADIUS = 3'd6;
  localparam logic [2:0] REG_TUBE_RADIUS = 3'd7;

  localparam logic signed [63:0] SMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] SMIN64 = -64'sd2147483648;
  localparam logic signed [36:0] ONE37 = 37'sd65536;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [17:0] axis_x;
    logic [17:0] axis_y;
    logic [17:0] axis_z;
    logic [30:0] ring_radius;
    logic [30:0] tube_radius;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_word_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] rem;
    logic [17:0] dvd;
    logic [17:0] quo;
    logic [30:0] dsr;
  } div_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SMAX64) begin
      return 32'sh7fffffff;
    end else if (v < SMIN64) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic sqrt_word_t sqrt_init(input logic valid, input logic [63:0] v);
    sqrt_word_t w;
    w.valid = valid;
    w.rad = v;
    w.rem = '0;
    w.root = '0;
    return w;
  endfunction

  function automatic div_word_t div_init(input logic valid, input logic [48:0] d,
                                         input logic [30:0] s);
    div_word_t w;
    w.valid = valid;
    w.rem = d[48:18];
    w.dvd = d[17:0];
    w.quo = '0;
    w.dsr = s;
    return w;
  endfunction

endpackage

FILE: hw/rtl/tdn_sqrt_cell.sv
// One step of the digit-by-digit integer square root: two radicand bits, one root bit.
module tdn_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdn_pkg::sqrt_word_t word_i,
  output tdn_pkg::sqrt_word_t word_o
);
  import tdn_pkg::*;

  logic [35:0] cur;
  logic [35:0] trial;
  sqrt_word_t  nxt;
  logic        valid_q;
  sqrt_word_t  data_q;

  always_comb begin
    cur = {word_i.rem, word_i.rad[63:62]};
    trial = {2'b00, word_i.root, 2'b01};
    nxt = word_i;
    nxt.rad = {word_i.rad[61:0], 2'b00};
    if (cur >= trial) begin
      nxt.rem = 34'(cur - trial);
      nxt.root = {word_i.root[30:0], 1'b1};
    end else begin
      nxt.rem = cur[33:0];
      nxt.root = {word_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    word_o = data_q;
    word_o.valid = valid_q;
  end

endmodule

FILE: hw/rtl/tdn_div_cell.sv
// One step of a restoring divider: one dividend bit in, one quotient bit out.
module tdn_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdn_pkg::div_word_t word_i,
  output tdn_pkg::div_word_t word_o
);
  import tdn_pkg::*;

  logic [31:0] cur;
  div_word_t   nxt;
  logic        valid_q;
  div_word_t   data_q;

  always_comb begin
    cur = {word_i.rem, word_i.dvd[17]};
    nxt = word_i;
    nxt.dvd = {word_i.dvd[16:0], 1'b0};
    if (cur >= {1'b0, word_i.dsr}) begin
      nxt.rem = 31'(cur - {1'b0, word_i.dsr});
      nxt.quo = {word_i.quo[16:0], 1'b1};
    end else begin
      nxt.rem = cur[30:0];
      nxt.quo = {word_i.quo[16:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    word_o = data_q;
    word_o.valid = valid_q;
  end

endmodule

FILE: hw/rtl/tdn_regs.sv
// APB configuration registers of the torus: center, axis and radii.
module tdn_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tdn_pkg::cfg_t cfg_o
);
  import tdn_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.center_z <= '0;
      cfg_q.axis_x <= '0;
      cfg_q.axis_y <= '0;
      cfg_q.axis_z <= 18'd65536;
      cfg_q.ring_radius <= 31'd131072;
      cfg_q.tube_radius <= 31'd65536;
    end else if (wr_en) begin
      case (idx)
        REG_CENTER_X: cfg_q.center_x <= pwdata;
        REG_CENTER_Y: cfg_q.center_y <= pwdata;
        REG_CENTER_Z: cfg_q.center_z <= pwdata;
        REG_AXIS_X: cfg_q.axis_x <= pwdata[17:0];
        REG_AXIS_Y: cfg_q.axis_y <= pwdata[17:0];
        REG_AXIS_Z: cfg_q.axis_z <= pwdata[17:0];
        REG_RING_RADIUS: cfg_q.ring_radius <= pwdata[30:0];
        REG_TUBE_RADIUS: cfg_q.tube_radius <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = cfg_q.center_x;
      REG_CENTER_Y: prdata = cfg_q.center_y;
      REG_CENTER_Z: prdata = cfg_q.center_z;
      REG_AXIS_X: prdata = {{14{cfg_q.axis_x[17]}}, cfg_q.axis_x};
      REG_AXIS_Y: prdata = {{14{cfg_q.axis_y[17]}}, cfg_q.axis_y};
      REG_AXIS_Z: prdata = {{14{cfg_q.axis_z[17]}}, cfg_q.axis_z};
      REG_RING_RADIUS: prdata = {1'b0, cfg_q.ring_radius};
      REG_TUBE_RADIUS: prdata = {1'b0, cfg_q.tube_radius};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/torus_distance_and_normal_top.sv
// Top level: pipelined torus signed distance and outward normal, one point per cycle.
// Throughput: one point per cycle; busy stays low, so every start pulse is taken.
// Most of the latency lies in the two 32-cell square-root chains and the two rows of 18-cell divider chains.
// Reset clears the valid bits of every stage and loads the default torus registers.
// Results are shown for one cycle under result_valid_o; the receiver cannot stall.
module torus_distance_and_normal_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  output logic        result_valid_o,
  output logic [31:0] distance_o,
  output logic [17:0] normal_x_o,
  output logic [17:0] normal_y_o,
  output logic [17:0] normal_z_o,
  output logic        degenerate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdn_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] w;
    logic [31:0]      axial;
    logic [63:0]      ax2;
  } side1_t;

  typedef struct packed {
    logic [2:0][31:0] w;
    logic [31:0]      axial;
    logic [30:0]      radial;
    logic [31:0]      dr;
  } side2_t;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [31:0]      sdist;
    logic             degen;
    logic [2:0][31:0] w;
    logic [30:0]      radial;
  } side3_t;

  typedef struct packed {
    logic [2:0]       sgn;
    logic [2:0][36:0] pa;
    logic [31:0]      sdist;
    logic             degen;
  } side4_t;

  cfg_t cfg;
  logic in_fire;
  logic [2:0][31:0] pt;
  logic [2:0][31:0] ctr;
  logic [2:0][17:0] ax;

  tdn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;
  assign in_fire = start && !busy;
  assign pt = {point_z_i, point_y_i, point_x_i};
  assign ctr = {cfg.center_z, cfg.center_y, cfg.center_x};
  assign ax = {cfg.axis_z, cfg.axis_y, cfg.axis_x};

  // Front stages: offset, axial projection, in-plane vector and squares.
  logic [6:0]       vf_q;
  logic [2:0][31:0] x1_q, x2_q, x3_q, x4_q;
  logic [2:0][49:0] m2_q, m4_q;
  logic [31:0]      axial3_q, axial4_q, axial5_q, axial6_q, axial7_q;
  logic [2:0][31:0] w5_q, w6_q, w7_q;
  logic [2:0][63:0] sq6_q;
  logic [63:0]      ax6_q, ax7_q, sum7_q;
  logic signed [51:0] acc3;

  always_comb begin
    acc3 = 52'($signed(m2_q[0])) + 52'($signed(m2_q[1])) + 52'($signed(m2_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= {vf_q[5:0], in_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      x1_q[i] <= sat32(64'($signed(pt[i])) - 64'($signed(ctr[i])));
      m2_q[i] <= 50'($signed(x1_q[i]) * $signed(ax[i]));
      m4_q[i] <= 50'($signed(axial3_q) * $signed(ax[i]));
      w5_q[i] <= sat32(64'($signed(x4_q[i]))
                       - 64'(sat32(64'($signed(m4_q[i]) >>> FB))));
      sq6_q[i] <= 64'(abs32(w5_q[i])) * 64'(abs32(w5_q[i]));
    end
    x2_q <= x1_q;
    x3_q <= x2_q;
    x4_q <= x3_q;
    axial3_q <= sat32(64'(acc3 >>> FB));
    axial4_q <= axial3_q;
    axial5_q <= axial4_q;
    axial6_q <= axial5_q;
    axial7_q <= axial6_q;
    w6_q <= w5_q;
    w7_q <= w6_q;
    ax6_q <= 64'(abs32(axial5_q)) * 64'(abs32(axial5_q));
    ax7_q <= ax6_q;
    sum7_q <= sq6_q[0] + sq6_q[1] + sq6_q[2];
  end

  // First square-root chain: in-plane length.
  sqrt_word_t sqa [SQRT_STEPS+1];
  side1_t     side1_q [SQRT_STEPS];

  assign sqa[0] = sqrt_init(vf_q[6], sum7_q);

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqa
    tdn_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (sqa[k]),
      .word_o (sqa[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side1_q[0] <= '{w: w7_q, axial: axial7_q, ax2: ax7_q};
    for (int k = 1; k < SQRT_STEPS; k++) begin
      side1_q[k] <= side1_q[k-1];
    end
  end

  // Radial stages: radius, offset from the core circle and the core sum.
  logic [2:0]  vr_q;
  logic [30:0] radial1_q, radial2_q, radial3_q;
  logic [31:0] dr1_q, dr2_q, dr3_q;
  logic [63:0] drsq2_q, csum3_q;
  side1_t      sr1_q, sr2_q, sr3_q;
  logic [30:0] radial_d;

  assign radial_d = sqa[SQRT_STEPS].root[31] ? 31'h7fffffff : sqa[SQRT_STEPS].root[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= '0;
    end else begin
      vr_q <= {vr_q[1:0], sqa[SQRT_STEPS].valid};
    end
  end

  always_ff @(posedge clk_i) begin
    radial1_q <= radial_d;
    dr1_q <= {1'b0, radial_d} - {1'b0, cfg.ring_radius};
    sr1_q <= side1_q[SQRT_STEPS-1];
    radial2_q <= radial1_q;
    dr2_q <= dr1_q;
    drsq2_q <= 64'(abs32(dr1_q)) * 64'(abs32(dr1_q));
    sr2_q <= sr1_q;
    radial3_q <= radial2_q;
    dr3_q <= dr2_q;
    csum3_q <= drsq2_q + sr2_q.ax2;
    sr3_q <= sr2_q;
  end

  // Second square-root chain: distance to the core circle.
  sqrt_word_t sqb [SQRT_STEPS+1];
  side2_t     side2_q [SQRT_STEPS];

  assign sqb[0] = sqrt_init(vr_q[2], csum3_q);

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqb
    tdn_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (sqb[k]),
      .word_o (sqb[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side2_q[0] <= '{w: sr3_q.w, axial: sr3_q.axial, radial: radial3_q, dr: dr3_q};
    for (int k = 1; k < SQRT_STEPS; k++) begin
      side2_q[k] <= side2_q[k-1];
    end
  end

  // Core stage: distance, degenerate flag and divider operands.
  logic        vc_q;
  logic [30:0] core_q;
  logic [31:0] dist_q;
  logic        degen_q;
  side2_t      sc_q;
  logic [30:0] core_d;

  assign core_d = sqb[SQRT_STEPS].root[31] ? 31'h7fffffff : sqb[SQRT_STEPS].root[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= sqb[SQRT_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    core_q <= core_d;
    dist_q <= {1'b0, core_d} - {1'b0, cfg.tube_radius};
    degen_q <= (side2_q[SQRT_STEPS-1].radial == '0) || (core_d == '0);
    sc_q <= side2_q[SQRT_STEPS-1];
  end

  // Divider chains for the axial and radial parts of the normal.
  div_word_t dvx [DIV_Q+1];
  div_word_t dvy [DIV_Q+1];
  side3_t    side3_q [DIV_Q];

  assign dvx[0] = div_init(vc_q, {1'b0, abs32(sc_q.axial), 16'b0}, core_q);
  assign dvy[0] = div_init(vc_q, {1'b0, abs32(sc_q.dr), 16'b0}, core_q);

  for (genvar k = 0; k < DIV_Q; k++) begin : g_dva
    tdn_div_cell u_cx (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (dvx[k]),
      .word_o (dvx[k+1])
    );
    tdn_div_cell u_cy (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (dvy[k]),
      .word_o (dvy[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side3_q[0] <= '{sx: sc_q.axial[31], sy: sc_q.dr[31], sdist: dist_q, degen: degen_q,
                    w: sc_q.w, radial: sc_q.radial};
    for (int k = 1; k < DIV_Q; k++) begin
      side3_q[k] <= side3_q[k-1];
    end
  end

  // Scale stages: signed quotients, then products with the axis and in-plane vector.
  logic [1:0]       vp_q;
  logic [18:0]      pnx1_q, pny1_q;
  side3_t           sp1_q;
  logic [2:0][50:0] pw2_q;
  logic [2:0][36:0] pa2_q;
  side3_t           sp2_q;
  logic [18:0]      qx_mag, qy_mag;

  assign qx_mag = {1'b0, dvx[DIV_Q].quo};
  assign qy_mag = {1'b0, dvy[DIV_Q].quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else begin
      vp_q <= {vp_q[0], dvx[DIV_Q].valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pnx1_q <= side3_q[DIV_Q-1].sx ? (~qx_mag + 19'd1) : qx_mag;
    pny1_q <= side3_q[DIV_Q-1].sy ? (~qy_mag + 19'd1) : qy_mag;
    sp1_q <= side3_q[DIV_Q-1];
    for (int i = 0; i < 3; i++) begin
      pw2_q[i] <= 51'($signed(pny1_q) * $signed(sp1_q.w[i]));
      pa2_q[i] <= 37'($signed(pnx1_q) * $signed(ax[i]));
    end
    sp2_q <= sp1_q;
  end

  // Divider chains for the in-plane part, one per axis.
  div_word_t dvc [3][DIV_Q+1];
  side4_t    side4_q [DIV_Q];
  logic [2:0][50:0] pw_mag;

  for (genvar i = 0; i < 3; i++) begin : g_dvc
    assign pw_mag[i] = pw2_q[i][50] ? (~pw2_q[i] + 51'd1) : pw2_q[i];
    assign dvc[i][0] = div_init(vp_q[1], pw_mag[i][48:0], sp2_q.radial);
    for (genvar k = 0; k < DIV_Q; k++) begin : g_cell
      tdn_div_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .word_i (dvc[i][k]),
        .word_o (dvc[i][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q[0] <= '{sgn: {pw2_q[2][50], pw2_q[1][50], pw2_q[0][50]}, pa: pa2_q,
                    sdist: sp2_q.sdist, degen: sp2_q.degen};
    for (int k = 1; k < DIV_Q; k++) begin
      side4_q[k] <= side4_q[k-1];
    end
  end

  // Output stage: sum of both parts, clamped to the unit range, or zero for a degenerate word.
  logic             vo_q;
  logic [2:0][17:0] n_d;
  logic [2:0][17:0] n_q;
  logic [31:0]      dist_o_q;
  logic             degen_o_q;
  logic signed [36:0] t [3];
  logic [18:0]      qm [3];
  logic [18:0]      qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = {1'b0, dvc[i][DIV_Q].quo};
      qs[i] = side4_q[DIV_Q-1].sgn[i] ? (~qm[i] + 19'd1) : qm[i];
      t[i] = ($signed(side4_q[DIV_Q-1].pa[i]) >>> FB) + 37'($signed(qs[i]));
      if (side4_q[DIV_Q-1].degen) begin
        n_d[i] = '0;
      end else if (t[i] > ONE37) begin
        n_d[i] = 18'sd65536;
      end else if (t[i] < -ONE37) begin
        n_d[i] = -18'sd65536;
      end else begin
        n_d[i] = t[i][17:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dvc[0][DIV_Q].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    dist_o_q <= side4_q[DIV_Q-1].sdist;
    degen_o_q <= side4_q[DIV_Q-1].degen;
  end

  assign result_valid_o = vo_q;
  assign distance_o = dist_o_q;
  assign normal_x_o = n_q[0];
  assign normal_y_o = n_q[1];
  assign normal_z_o = n_q[2];
  assign degenerate_o = degen_o_q;

  // Every accepted point produces a result word; the check uses the LATENCY parameter of the package.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##LATENCY result_valid_o)
    else $error("result word missing after fixed latency");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate word carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ($signed(normal_x_o) <= 18'sd65536 && $signed(normal_x_o) >= -18'sd65536 &&
       $signed(normal_y_o) <= 18'sd65536 && $signed(normal_y_o) >= -18'sd65536 &&
       $signed(normal_z_o) <= 18'sd65536 && $signed(normal_z_o) >= -18'sd65536))
    else $error("normal component outside unit range");

  // The core distance is never negative, so the distance never drops below -tube.
  a_dist_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($signed(distance_o) >= -$signed({1'b0, cfg.tube_radius})))
    else $error("distance below negative tube radius");

endmodule

FILE: tb/torus_distance_and_normal_checker.sv
// Checker for the torus block: tracks register writes, predicts each result word and compares.
module torus_distance_and_normal_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic        result_valid_i,
  input  logic [31:0] distance_i,
  input  logic [17:0] normal_x_i,
  input  logic [17:0] normal_y_i,
  input  logic [17:0] normal_z_i,
  input  logic        degenerate_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);
  import tdn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] distance;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] nz;
    logic        degen;
  } torus_word_t;

  longint center[3];
  longint axis[3];
  longint ring_r;
  longint tube_r;
  torus_word_t expected_words[$];
  int fails;

  function automatic longint clip_coord(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag_sq(input longint v);
    longint unsigned u;
    u = (v < 0) ? longint'(-v) : longint'(v);
    return u * u;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic torus_word_t torus_fit(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz);
    longint pt[3];
    longint off[3];
    longint inp[3];
    longint nrm[3];
    longint acc, axial, radial, dr, core, sdist, pnx, pny;
    longint unsigned sum;
    torus_word_t r;
    pt[0] = longint'($signed(px));
    pt[1] = longint'($signed(py));
    pt[2] = longint'($signed(pz));
    acc = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      off[i] = clip_coord(pt[i] - center[i]);
      acc += off[i] * axis[i];
    end
    axial = clip_coord(acc >>> FB);
    for (int i = 0; i < 3; i++) begin
      inp[i] = clip_coord(off[i] - clip_coord((axial * axis[i]) >>> FB));
      sum += mag_sq(inp[i]);
    end
    radial = clip_coord(longint'(floor_sqrt(sum)));
    dr = clip_coord(radial - ring_r);
    core = clip_coord(longint'(floor_sqrt(mag_sq(dr) + mag_sq(axial))));
    sdist = clip_coord(core - tube_r);
    r.degen = (radial == 0) || (core == 0);
    if (r.degen) begin
      nrm[0] = 0; nrm[1] = 0; nrm[2] = 0;
    end else begin
      pnx = (axial * 65536) / core;
      pny = (dr * 65536) / core;
      for (int i = 0; i < 3; i++)
        nrm[i] = clamp_unit(((pnx * axis[i]) >>> FB) + (pny * inp[i]) / radial);
    end
    r.distance = sdist[31:0];
    r.nx = nrm[0][17:0];
    r.ny = nrm[1][17:0];
    r.nz = nrm[2][17:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    torus_word_t e;
    if (!rst_ni) begin
      center[0] <= 0; center[1] <= 0; center[2] <= 0;
      axis[0] <= 0; axis[1] <= 0; axis[2] <= 65536;
      ring_r <= 131072;
      tube_r <= 65536;
      expected_words.delete();
      fails <= 0;
    end else begin
      // Registers only change while the pipe is idle, so ordering against points is safe.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_CENTER_X:    center[0] <= longint'($signed(pwdata_i));
          REG_CENTER_Y:    center[1] <= longint'($signed(pwdata_i));
          REG_CENTER_Z:    center[2] <= longint'($signed(pwdata_i));
          REG_AXIS_X:      axis[0] <= longint'($signed(pwdata_i[17:0]));
          REG_AXIS_Y:      axis[1] <= longint'($signed(pwdata_i[17:0]));
          REG_AXIS_Z:      axis[2] <= longint'($signed(pwdata_i[17:0]));
          REG_RING_RADIUS: ring_r <= longint'({1'b0, pwdata_i[30:0]});
          REG_TUBE_RADIUS: tube_r <= longint'({1'b0, pwdata_i[30:0]});
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_words.push_back(torus_fit(point_x_i, point_y_i, point_z_i));
      if (result_valid_i) begin
        if (expected_words.size() == 0) begin
          if (fails < 10) $display("ERROR: result word with nothing expected");
          fails <= fails + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.distance !== distance_i || e.nx !== normal_x_i || e.ny !== normal_y_i ||
              e.nz !== normal_z_i || e.degen !== degenerate_i) begin
            if (fails < 10)
              $display("ERROR: exp dist=%h n=%h/%h/%h deg=%b, got dist=%h n=%h/%h/%h deg=%b",
                       e.distance, e.nx, e.ny, e.nz, e.degen, distance_i, normal_x_i,
                       normal_y_i, normal_z_i, degenerate_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o = expected_words.size();

endmodule

FILE: tb/tb_torus_distance_and_normal_top.sv
// Testbench top: drives points and register writes into the torus block and gives the verdict.
module tb_torus_distance_and_normal_top;
  import tdn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] point_x, point_y, point_z;
  logic        result_valid;
  logic [31:0] distance;
  logic [17:0] normal_x, normal_y, normal_z;
  logic        degenerate;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          idle_pct;
  logic [31:0] cur_center[3];

  torus_distance_and_normal_top dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .result_valid_o(result_valid), .distance_o(distance),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .degenerate_o(degenerate),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  torus_distance_and_normal_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .result_valid_i(result_valid), .distance_i(distance),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .normal_z_i(normal_z),
    .degenerate_i(degenerate),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Offset near the torus in most cases so the normal math is exercised, else any value.
  function automatic logic [31:0] near_coord(input logic [31:0] c);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return c + 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    if (sel < 85) return c + 32'($signed($urandom_range(1 << 27)) - (1 << 26));
    return $urandom;
  endfunction

  task automatic set_torus(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                           input logic [17:0] ax, input logic [17:0] ay, input logic [17:0] az,
                           input logic [30:0] ring, input logic [30:0] tube);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_CENTER_Z, cz);
    reg_write(REG_AXIS_X, {{14{ax[17]}}, ax});
    reg_write(REG_AXIS_Y, {{14{ay[17]}}, ay});
    reg_write(REG_AXIS_Z, {{14{az[17]}}, az});
    reg_write(REG_RING_RADIUS, {1'b0, ring});
    reg_write(REG_TUBE_RADIUS, {1'b0, tube});
    cur_center[0] = cx;
    cur_center[1] = cy;
    cur_center[2] = cz;
  endtask

  initial begin
    logic [17:0] ax, ay, az;
    int unsigned sel;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    point_x = '0; point_y = '0; point_z = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_center[0] = '0; cur_center[1] = '0; cur_center[2] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset torus: axis points, core circle, surface, extremes.
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0005_0000);
    send_point(32'h0, 32'h0, 32'hfffb_0000);
    send_point(32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'hfffe_0000, 32'h0);
    send_point(32'h0003_0000, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    send_point(32'h0002_0000, 32'h0, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0, 32'hffff_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h0, 32'h7fff_ffff);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0);
    send_point(32'h0001_6a09, 32'h0001_6a09, 32'h0);
    send_point(32'h0, 32'h0, 32'h8000_0000);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_torus(32'h8000_0000, 32'h7fff_ffff, 32'h0, 18'h10000, 18'h0, 18'h0,
                     31'h7fff_ffff, 31'h0);
        1: set_torus(32'h0, 32'h0, 32'h0, 18'h0, 18'h30000, 18'h0, 31'h0, 31'h7fff_ffff);
        2: set_torus(32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 18'h0, 18'h0, 18'h30000,
                     31'h0003_0000, 31'h0000_8000);
        default: begin
          // Random axis, sometimes a unit vector, sometimes any value in range.
          sel = $urandom_range(3);
          ax = 18'($signed($urandom_range(131072)) - 65536);
          ay = 18'($signed($urandom_range(131072)) - 65536);
          az = 18'($signed($urandom_range(131072)) - 65536);
          if (sel == 0) begin
            ax = 18'h0; ay = 18'h0; az = 18'h10000;
          end else if (sel == 1) begin
            ax = 18'h0b505; ay = 18'h0b505; az = 18'h0;
          end
          set_torus(32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                    32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                    32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                    ax, ay, az, 31'($urandom_range(1 << 20)), 31'($urandom_range(1 << 19)));
        end
      endcase
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 65;
        2: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      for (int k = 0; k < 300; k++) begin
        sel = $urandom_range(99);
        if (sel < 3)
          send_point(cur_center[0], cur_center[1], cur_center[2]);
        else
          send_point(near_coord(cur_center[0]), near_coord(cur_center[1]),
                     near_coord(cur_center[2]));
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
